// File: src/rrfb_pkg.sv
package rrfb_pkg;

  localparam int ColW   = 12;
  localparam int RadW   = 11;
  localparam int CoordW = 16;
  localparam int PixW   = 32;
  localparam int ChanW  = 8;

  localparam logic [ChanW-1:0] AlphaOpaque = 8'hFF;
  localparam logic [ChanW-1:0] AlphaClear  = 8'h00;

  typedef enum logic [2:0] {
    REG_RECT_WIDTH    = 3'd0,
    REG_RECT_HEIGHT   = 3'd1,
    REG_CORNER_RADIUS = 3'd2,
    REG_FILL_COLOR    = 3'd3,
    REG_CLIP_X0       = 3'd4,
    REG_CLIP_Y0       = 3'd5,
    REG_CLIP_X1       = 3'd6,
    REG_CLIP_Y1       = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [ColW-1:0] width;
    logic [ColW-1:0] height;
    logic [RadW-1:0] radius;
  } rect_cfg_t;

endpackage

// File: src/rrfb_cover.sv
module rrfb_cover import rrfb_pkg::*; (
  input  logic            clk_i,
  input  rect_cfg_t       cfg_i,
  input  logic [ColW-1:0] column_i,
  input  logic [ColW-1:0] row_i,
  output logic            covered_o
);

  localparam int SqW = 2 * RadW;

  logic [ColW:0]   two_r;
  logic            r_too_big;
  logic [RadW-1:0] r_eff;
  logic [ColW-1:0] r12;
  logic [ColW-1:0] w_less_r;
  logic [ColW-1:0] h_less_r;
  logic [ColW-1:0] dx12;
  logic [ColW-1:0] dy12;
  logic            in_rect_d;
  logic            pass_d;

  logic            in_rect_q;
  logic            pass_q;
  logic [RadW-1:0] dx_q;
  logic [RadW-1:0] dy_q;
  logic [RadW-1:0] r_q;

  logic            in_rect2_q;
  logic            pass2_q;
  logic [SqW-1:0]  dx2_q;
  logic [SqW-1:0]  dy2_q;
  logic [SqW-1:0]  r2_q;

  always_comb begin
    two_r     = {cfg_i.radius, 1'b0};
    r_too_big = ({1'b0, cfg_i.width} <= two_r) || ({1'b0, cfg_i.height} <= two_r);
    r_eff     = r_too_big ? '0 : cfg_i.radius;
    r12       = {1'b0, r_eff};
    w_less_r  = cfg_i.width - r12;
    h_less_r  = cfg_i.height - r12;
    in_rect_d = (column_i < cfg_i.width) && (row_i < cfg_i.height);
    pass_d    = (r_eff == '0) ||
                ((column_i >= r12) && (column_i < w_less_r)) ||
                ((row_i >= r12) && (row_i < h_less_r));
    dx12      = (column_i < r12) ? (r12 - 12'd1 - column_i) : (column_i - w_less_r);
    dy12      = (row_i < r12) ? (r12 - 12'd1 - row_i) : (row_i - h_less_r);
  end

  always_ff @(posedge clk_i) begin
    in_rect_q  <= in_rect_d;
    pass_q     <= pass_d;
    dx_q       <= dx12[RadW-1:0];
    dy_q       <= dy12[RadW-1:0];
    r_q        <= r_eff;
    in_rect2_q <= in_rect_q;
    pass2_q    <= pass_q;
    dx2_q      <= SqW'(dx_q) * SqW'(dx_q);
    dy2_q      <= SqW'(dy_q) * SqW'(dy_q);
    r2_q       <= SqW'(r_q) * SqW'(r_q);
  end

  assign covered_o = in_rect2_q &&
                     (pass2_q || (({1'b0, dx2_q} + {1'b0, dy2_q}) < {1'b0, r2_q}));

endmodule

// File: src/rrfb_blend.sv
module rrfb_blend import rrfb_pkg::*; (
  input  logic            clk_i,
  input  logic [PixW-1:0] fill_i,
  input  logic [PixW-1:0] dest_i,
  output logic [PixW-1:0] pixel_o
);

  localparam int ProdW = 2 * ChanW;
  localparam int NChan = 3;

  logic [ChanW-1:0]            alpha;
  logic [ChanW-1:0]            inv_alpha;
  logic [NChan-1:0][ProdW-1:0] prod_d;
  logic [NChan-1:0][ProdW-1:0] prod_q;
  logic                        opaque_q;
  logic                        clear_q;
  logic [PixW-1:0]             fill_q;
  logic [PixW-1:0]             dest_q;
  logic [NChan-1:0][ChanW-1:0] quot;
  logic [PixW-1:0]             pixel_d;
  logic [PixW-1:0]             pixel_q;

  assign alpha     = fill_i[PixW-1 -: ChanW];
  assign inv_alpha = AlphaOpaque - alpha;

  always_comb begin
    for (int c = 0; c < NChan; c++) begin
      prod_d[c] = ProdW'(fill_i[c*ChanW +: ChanW]) * ProdW'(alpha) +
                  ProdW'(dest_i[c*ChanW +: ChanW]) * ProdW'(inv_alpha);
    end
  end

  always_comb begin
    logic [ProdW:0] t;
    logic [ProdW:0] u;
    for (int c = 0; c < NChan; c++) begin
      t       = {1'b0, prod_q[c]} + 17'd1;
      u       = t + (t >> ChanW);
      quot[c] = u[ProdW-1:ChanW];
    end
    if (opaque_q) begin
      pixel_d = fill_q;
    end else if (clear_q) begin
      pixel_d = dest_q;
    end else begin
      pixel_d = {AlphaOpaque, quot[2], quot[1], quot[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    opaque_q <= (alpha == AlphaOpaque);
    clear_q  <= (alpha == AlphaClear);
    fill_q   <= fill_i;
    dest_q   <= dest_i;
    pixel_q  <= pixel_d;
  end

  assign pixel_o = pixel_q;

endmodule

// File: src/rounded_rect_fill_blend.sv
// done_o is registered through valid1_q, valid2_q and done_q after the edge that takes a
// request. Throughput: one pixel per clock; busy_o stays low, so a request may come every
// cycle.
// The pipeline has three register stages: the corner offsets, their squares and the output.
// The receiver cannot stall; results are shown for one cycle only.
// Reset clears the valid bits and loads the register reset values; payload is not reset.
module rounded_rect_fill_blend import rrfb_pkg::*; #(
  parameter int CANVAS_COLS = 800,
  parameter int CANVAS_ROWS = 600
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  output logic                     done_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_index_i,
  input  logic [PixW-1:0]          cfg_wdata_i,
  input  logic [ColW-1:0]          column_i,
  input  logic [ColW-1:0]          row_i,
  input  logic signed [CoordW-1:0] canvas_x_i,
  input  logic signed [CoordW-1:0] canvas_y_i,
  input  logic [PixW-1:0]          dest_pixel_i,
  output logic                     write_enable_o,
  output logic [PixW-1:0]          new_pixel_o
);

  localparam logic signed [CoordW:0] CanvasW = (CoordW+1)'(CANVAS_COLS);
  localparam logic signed [CoordW:0] CanvasH = (CoordW+1)'(CANVAS_ROWS);

  logic [ColW-1:0]          rect_width_q;
  logic [ColW-1:0]          rect_height_q;
  logic [RadW-1:0]          corner_radius_q;
  logic [PixW-1:0]          fill_color_q;
  logic signed [CoordW-1:0] clip_x0_q;
  logic signed [CoordW-1:0] clip_y0_q;
  logic signed [CoordW-1:0] clip_x1_q;
  logic signed [CoordW-1:0] clip_y1_q;

  rect_cfg_t                rect_cfg;
  logic signed [CoordW:0]   x_ext;
  logic signed [CoordW:0]   y_ext;
  logic                     pos_ok;
  logic                     covered;
  logic [PixW-1:0]          blended;

  logic                     valid1_q;
  logic                     valid2_q;
  logic                     pos_ok1_q;
  logic                     pos_ok2_q;
  logic [PixW-1:0]          dest1_q;
  logic [PixW-1:0]          dest2_q;
  logic                     done_q;
  logic                     we_q;
  logic [PixW-1:0]          pixel_q;
  logic                     we_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_width_q    <= '0;
      rect_height_q   <= '0;
      corner_radius_q <= '0;
      fill_color_q    <= '0;
      clip_x0_q       <= '0;
      clip_y0_q       <= '0;
      clip_x1_q       <= 16'sd800;
      clip_y1_q       <= 16'sd600;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_RECT_WIDTH:    rect_width_q    <= cfg_wdata_i[ColW-1:0];
        REG_RECT_HEIGHT:   rect_height_q   <= cfg_wdata_i[ColW-1:0];
        REG_CORNER_RADIUS: corner_radius_q <= cfg_wdata_i[RadW-1:0];
        REG_FILL_COLOR:    fill_color_q    <= cfg_wdata_i;
        REG_CLIP_X0:       clip_x0_q       <= cfg_wdata_i[CoordW-1:0];
        REG_CLIP_Y0:       clip_y0_q       <= cfg_wdata_i[CoordW-1:0];
        REG_CLIP_X1:       clip_x1_q       <= cfg_wdata_i[CoordW-1:0];
        REG_CLIP_Y1:       clip_y1_q       <= cfg_wdata_i[CoordW-1:0];
        default:           ;
      endcase
    end
  end

  assign rect_cfg.width  = rect_width_q;
  assign rect_cfg.height = rect_height_q;
  assign rect_cfg.radius = corner_radius_q;

  assign x_ext  = {canvas_x_i[CoordW-1], canvas_x_i};
  assign y_ext  = {canvas_y_i[CoordW-1], canvas_y_i};
  assign pos_ok = !canvas_x_i[CoordW-1] && !canvas_y_i[CoordW-1] &&
                  (x_ext < CanvasW) && (y_ext < CanvasH) &&
                  (canvas_x_i >= clip_x0_q) && (canvas_y_i >= clip_y0_q) &&
                  (canvas_x_i < clip_x1_q) && (canvas_y_i < clip_y1_q);

  rrfb_cover u_cover (
    .clk_i     (clk_i),
    .cfg_i     (rect_cfg),
    .column_i  (column_i),
    .row_i     (row_i),
    .covered_o (covered)
  );

  rrfb_blend u_blend (
    .clk_i   (clk_i),
    .fill_i  (fill_color_q),
    .dest_i  (dest_pixel_i),
    .pixel_o (blended)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      valid1_q <= start_i && !busy_o;
      valid2_q <= valid1_q;
      done_q   <= valid2_q;
    end
  end

  assign we_d = covered && pos_ok2_q;

  always_ff @(posedge clk_i) begin
    pos_ok1_q <= pos_ok;
    pos_ok2_q <= pos_ok1_q;
    dest1_q   <= dest_pixel_i;
    dest2_q   <= dest1_q;
    we_q      <= we_d;
    pixel_q   <= we_d ? blended : dest2_q;
  end

  assign busy_o         = 1'b0;
  assign done_o         = done_q;
  assign write_enable_o = we_q;
  assign new_pixel_o    = pixel_q;

endmodule
